// File: hw/rtl/blocking_message_queue_assert.svh
// ----------------------------------------------------------------------------
// Blocking message queue assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOCKING_MESSAGE_QUEUE_ASSERT_SVH
`define BLOCKING_MESSAGE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// check on every clock edge, reset included
`define BMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// check only outside reset
`define BMQ_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define BMQ_ASSERT(lbl, prop, msg)
`define BMQ_ASSERT_RUN(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/bmq_pkg.sv
// ----------------------------------------------------------------------------
// Blocking message queue package
// Sizes, command and status codes, message trimming.
// ----------------------------------------------------------------------------
`default_nettype none

package bmq_pkg;

  localparam int RING_DEPTH  = 256;
  localparam int MAX_WAITERS = 16;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int EW  = PW + 1;
  localparam int WW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CW  = $clog2(MAX_WAITERS + 1);

  localparam int MSG_W  = 64;
  localparam int TASK_W = 4;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 3;
  localparam int CAP_W  = 9;
  localparam int NB_W   = 4;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 4;

  localparam logic [CMD_W-1:0] CMD_SEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEND_ISR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECV     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [ST_W-1:0] ST_ERROR    = 3'd2;
  localparam logic [ST_W-1:0] ST_TIMEOUT  = 3'd3;
  localparam logic [ST_W-1:0] ST_BUSY     = 3'd4;
  localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd5;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd6;

  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_MSG_BYTES = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET   = 9'd16;
  localparam logic [NB_W-1:0]  BYTES_RESET = 4'd4;

  // keep only the low nb bytes; zero acts as one
  function automatic logic [MSG_W-1:0] trim_msg(input logic [MSG_W-1:0] m,
                                                input logic [NB_W-1:0] nb);
    logic [MSG_W-1:0] r;
    r = m;
    for (int j = 1; j < 8; j++) begin
      if (NB_W'(j) >= nb) r[8*j +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/blocking_message_queue.sv
// ----------------------------------------------------------------------------
// Blocking message queue
// One RTOS-style message queue with FIFO lists of blocked senders/receivers.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and answers with one or more
// result words: wakes of blocked tasks first, the reply to the caller last
// (tlast set). Messages live in a ring RAM of RING_DEPTH entries, blocked
// senders (id and message) and blocked receivers in two circular RAMs of
// MAX_WAITERS entries. All three are synchronous single-read RAMs, so one
// command goes through: accept, decide, a ring read for a receive that finds
// data, an optional wake, then the reply. Delete walks both wait lists
// through DEL_RD and DEL_EM for each waiter; cancel searches through CS_RD
// and CS_CHK for each entry looked at and closes the gap through CP_RD and
// CP_WR for each entry moved. No clearing pass is needed after reset.
// Configuration must be written only while idle; it is not enforced here.
`default_nettype none

`include "blocking_message_queue_assert.svh"

module blocking_message_queue (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // command words
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bmq_pkg::IN_DATA_W-1:0]    s_tdata,  // task_id[3:0], msg_in[67:4]
  input  wire logic [bmq_pkg::IN_USER_W-1:0]    s_tuser,  // cmd[2:0], no_wait[3], sched_running[4]
  // result words
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [bmq_pkg::OUT_DATA_W-1:0]   m_tdata,  // target_task[3:0], msg_out[67:4]
  output logic      [bmq_pkg::OUT_USER_W-1:0]   m_tuser,  // is_wake[0], status[3:1]
  output logic                                  m_tlast,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [0:0]                       cfg_idx,
  input  wire logic [bmq_pkg::CAP_W-1:0]        cfg_data
);

  import bmq_pkg::*;

  typedef enum logic [3:0] {
    IDLE, DECIDE, SND_WK, RCV_D, RCV_WK, DEL_RD, DEL_EM,
    CS_RD, CS_CHK, CP_RD, CP_WR, REPLY
  } state_t;

  localparam int SW = MSG_W + TASK_W;

  state_t state;

  // configuration
  logic [CAP_W-1:0] cap;
  logic [NB_W-1:0]  nbytes;
  logic [EW-1:0]    eff_cap;

  // queue state
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [EW-1:0] fill;
  logic          alive;
  logic [WW-1:0] s_head, r_head;
  logic [CW-1:0] s_cnt, r_cnt;

  // latched command
  logic [CMD_W-1:0]  cmd;
  logic [TASK_W-1:0] task_id;
  logic [MSG_W-1:0]  msg;
  logic              no_wait, sched;

  logic [ST_W-1:0]  rep_st;
  logic [MSG_W-1:0] rep_msg;
  logic [CW-1:0]    k;
  logic             lst_rcv;   // walk the receiver list, else the sender list

  // RAM ports
  logic             ring_we, ring_re;
  logic [MSG_W-1:0] ring_wdata, ring_rdata;
  logic             sl_we, sl_re;
  logic [WW-1:0]    sl_waddr, sl_raddr;
  logic [SW-1:0]    sl_wdata, sl_rdata;
  logic             rl_we, rl_re;
  logic [WW-1:0]    rl_waddr, rl_raddr;
  logic [TASK_W-1:0] rl_wdata, rl_rdata;

  function automatic logic [WW-1:0] widx(input logic [WW-1:0] h, input logic [CW-1:0] off);
    logic [WW:0] s;
    s = (WW+1)'(h) + (WW+1)'(off);
    if (s >= (WW+1)'(MAX_WAITERS)) s = s - (WW+1)'(MAX_WAITERS);
    return s[WW-1:0];
  endfunction

  function automatic logic [WW-1:0] winc(input logic [WW-1:0] h);
    return (32'(h) == MAX_WAITERS - 1) ? '0 : WW'(h + 1'b1);
  endfunction

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [EW-1:0] ec);
    logic [EW-1:0] n;
    n = EW'(p) + EW'(1);
    return (n >= ec) ? '0 : n[PW-1:0];
  endfunction

  always_comb begin
    if (cap == '0) eff_cap = EW'(1);
    else if (32'(cap) > 32'(RING_DEPTH)) eff_cap = EW'(RING_DEPTH);
    else eff_cap = EW'(cap);
  end

  // decision terms for the latched command
  logic is_send, no_sched, go, have_rcv, space, s_full, r_full, not_empty;
  logic [CW-1:0]    walk_cnt;
  logic [TASK_W-1:0] walk_id;
  logic             can_emit;
  logic             emit_now;

  assign is_send   = (cmd == CMD_SEND) || (cmd == CMD_SEND_ISR);
  assign no_sched  = (cmd != CMD_SEND_ISR) && !sched;
  assign go        = (cmd == CMD_SEND || cmd == CMD_SEND_ISR || cmd == CMD_RECV)
                     && alive && !no_sched;
  assign have_rcv  = r_cnt != '0;
  assign space     = fill < eff_cap;
  assign not_empty = fill != '0;
  assign s_full    = 32'(s_cnt) >= MAX_WAITERS;
  assign r_full    = 32'(r_cnt) >= MAX_WAITERS;
  assign walk_cnt  = lst_rcv ? r_cnt : s_cnt;
  assign walk_id   = lst_rcv ? rl_rdata : sl_rdata[TASK_W-1:0];
  assign can_emit  = !m_tvalid || m_tready;
  // a word state loads the result register this cycle
  assign emit_now  = can_emit && (state == SND_WK || state == RCV_WK ||
                                  state == DEL_EM || state == REPLY);

  assign s_tready = (state == IDLE);

  // RAM control
  always_comb begin
    ring_we = 1'b0;  ring_re = 1'b0;  ring_wdata = trim_msg(msg, nbytes);
    sl_we = 1'b0;  sl_re = 1'b0;  sl_waddr = widx(s_head, s_cnt);  sl_raddr = s_head;
    sl_wdata = {trim_msg(msg, nbytes), task_id};
    rl_we = 1'b0;  rl_re = 1'b0;  rl_waddr = widx(r_head, r_cnt);  rl_raddr = r_head;
    rl_wdata = task_id;
    case (state)
      DECIDE: begin
        if (go && is_send) begin
          if (have_rcv) rl_re = 1'b1;
          else if (space) ring_we = 1'b1;
          else if (cmd == CMD_SEND && !no_wait && !s_full) sl_we = 1'b1;
        end else if (go) begin
          if (not_empty) begin
            ring_re = 1'b1;
            sl_re   = 1'b1;
          end else if (!no_wait && !r_full) begin
            rl_we = 1'b1;
          end
        end
      end
      RCV_D: begin
        // refill from the oldest blocked sender
        ring_wdata = trim_msg(sl_rdata[SW-1:TASK_W], nbytes);
        ring_we    = s_cnt != '0;
      end
      DEL_RD, CS_RD: begin
        sl_raddr = widx(s_head, k);
        rl_raddr = widx(r_head, k);
        if (k != walk_cnt) begin
          sl_re = !lst_rcv;
          rl_re = lst_rcv;
        end
      end
      CP_RD: begin
        sl_raddr = widx(s_head, CW'(k + 1'b1));
        rl_raddr = widx(r_head, CW'(k + 1'b1));
        if (CW'(k + 1'b1) != walk_cnt) begin
          sl_re = !lst_rcv;
          rl_re = lst_rcv;
        end
      end
      CP_WR: begin
        // move the next entry down into the gap
        sl_waddr = widx(s_head, k);
        rl_waddr = widx(r_head, k);
        sl_wdata = sl_rdata;
        rl_wdata = rl_rdata;
        sl_we    = !lst_rcv;
        rl_we    = lst_rcv;
      end
      default: ;
    endcase
  end

  bmq_ram #(.WIDTH(MSG_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk, .we(ring_we), .waddr(wr_ptr), .wdata(ring_wdata),
    .re(ring_re), .raddr(rd_ptr), .rdata(ring_rdata)
  );

  bmq_ram #(.WIDTH(SW), .DEPTH(MAX_WAITERS)) u_senders (
    .clk, .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .re(sl_re), .raddr(sl_raddr), .rdata(sl_rdata)
  );

  bmq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_WAITERS)) u_receivers (
    .clk, .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
    .re(rl_re), .raddr(rl_raddr), .rdata(rl_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CAP_RESET;
      nbytes <= BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAPACITY:  cap    <= cfg_data;
        REG_MSG_BYTES: nbytes <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      alive    <= 1'b1;
      s_head   <= '0;
      r_head   <= '0;
      s_cnt    <= '0;
      r_cnt    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // raise valid for a new result word, drop it once taken
      if (emit_now) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tuser[CMD_W-1:0];
            no_wait <= s_tuser[CMD_W];
            sched   <= s_tuser[CMD_W+1];
            task_id <= s_tdata[TASK_W-1:0];
            msg     <= s_tdata[TASK_W +: MSG_W];
            state   <= DECIDE;
          end
        end
        DECIDE: begin
          rep_msg <= '0;
          k       <= '0;
          lst_rcv <= 1'b0;
          state   <= REPLY;
          if (cmd > CMD_DELETE) begin
            rep_st <= ST_INVALID;
          end else if (cmd == CMD_CANCEL) begin
            rep_st <= ST_NOTFOUND;
            if (alive) state <= CS_RD;
          end else if (!alive) begin
            rep_st <= ST_INVALID;
          end else if (cmd == CMD_DELETE) begin
            state <= DEL_RD;
          end else if (no_sched) begin
            rep_st <= ST_ERROR;
          end else if (is_send) begin
            rep_st <= ST_OK;
            if (have_rcv) begin
              state <= SND_WK;
            end else if (space) begin
              wr_ptr <= advance(wr_ptr, eff_cap);
              fill   <= EW'(fill + 1'b1);
            end else if (cmd == CMD_SEND_ISR) begin
              rep_st <= ST_BUSY;
            end else if (no_wait) begin
              rep_st <= ST_TIMEOUT;
            end else if (s_full) begin
              rep_st <= ST_BUSY;
            end else begin
              s_cnt  <= CW'(s_cnt + 1'b1);
              rep_st <= ST_BLOCKED;
            end
          end else begin
            rep_st <= ST_OK;
            if (not_empty) begin
              state <= RCV_D;
            end else if (no_wait) begin
              rep_st <= ST_TIMEOUT;
            end else if (r_full) begin
              rep_st <= ST_BUSY;
            end else begin
              r_cnt  <= CW'(r_cnt + 1'b1);
              rep_st <= ST_BLOCKED;
            end
          end
        end
        SND_WK: begin
          if (can_emit) begin
            m_tdata  <= {{(OUT_DATA_W-SW){1'b0}}, trim_msg(msg, nbytes), rl_rdata};
            m_tuser  <= {ST_OK, 1'b1};
            m_tlast  <= 1'b0;
            r_head   <= winc(r_head);
            r_cnt    <= CW'(r_cnt - 1'b1);
            state    <= REPLY;
          end
        end
        RCV_D: begin
          rep_msg <= trim_msg(ring_rdata, nbytes);
          rd_ptr  <= advance(rd_ptr, eff_cap);
          if (s_cnt != '0) begin
            wr_ptr <= advance(wr_ptr, eff_cap);
            s_head <= winc(s_head);
            s_cnt  <= CW'(s_cnt - 1'b1);
            state  <= RCV_WK;
          end else begin
            fill  <= EW'(fill - 1'b1);
            state <= REPLY;
          end
        end
        RCV_WK: begin
          if (can_emit) begin
            m_tdata  <= {{(OUT_DATA_W-TASK_W){1'b0}}, sl_rdata[TASK_W-1:0]};
            m_tuser  <= {ST_OK, 1'b1};
            m_tlast  <= 1'b0;
            state    <= REPLY;
          end
        end
        DEL_RD: begin
          if (k != walk_cnt) begin
            state <= DEL_EM;
          end else if (!lst_rcv) begin
            lst_rcv <= 1'b1;
            k       <= '0;
          end else begin
            s_cnt  <= '0;
            r_cnt  <= '0;
            alive  <= 1'b0;
            rep_st <= ST_OK;
            state  <= REPLY;
          end
        end
        DEL_EM: begin
          if (can_emit) begin
            m_tdata  <= {{(OUT_DATA_W-TASK_W){1'b0}}, walk_id};
            m_tuser  <= {ST_ERROR, 1'b1};
            m_tlast  <= 1'b0;
            k        <= CW'(k + 1'b1);
            state    <= DEL_RD;
          end
        end
        CS_RD: begin
          if (k != walk_cnt) begin
            state <= CS_CHK;
          end else if (!lst_rcv) begin
            lst_rcv <= 1'b1;
            k       <= '0;
          end else begin
            state <= REPLY;
          end
        end
        CS_CHK: begin
          if (walk_id == task_id) begin
            state <= CP_RD;
          end else begin
            k     <= CW'(k + 1'b1);
            state <= CS_RD;
          end
        end
        CP_RD: begin
          if (CW'(k + 1'b1) == walk_cnt) begin
            if (lst_rcv) r_cnt <= CW'(r_cnt - 1'b1);
            else         s_cnt <= CW'(s_cnt - 1'b1);
            rep_st <= ST_OK;
            state  <= REPLY;
          end else begin
            state <= CP_WR;
          end
        end
        CP_WR: begin
          k     <= CW'(k + 1'b1);
          state <= CP_RD;
        end
        REPLY: begin
          if (can_emit) begin
            m_tdata  <= {{(OUT_DATA_W-SW){1'b0}}, rep_msg, task_id};
            m_tuser  <= {rep_st, 1'b0};
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // a deleted queue holds no waiters
  `BMQ_ASSERT_RUN(a_dead_empty, !alive |-> (s_cnt == '0 && r_cnt == '0), "waiters on deleted queue")
  // the reply closing a command is never a wake
  `BMQ_ASSERT_RUN(a_last_reply, (m_tvalid && m_tlast) |-> !m_tuser[0], "tlast on a wake word")
  // the ring never holds more than its depth
  `BMQ_ASSERT_RUN(a_fill_bound, 32'(fill) <= RING_DEPTH, "ring fill overflow")
  // a command is accepted only in idle and then moves on to decide
  `BMQ_ASSERT_RUN(a_accept_idle, (s_tvalid && s_tready) |=> state == DECIDE, "accept outside idle")

endmodule

`default_nettype wire

// File: hw/rtl/bmq_ram.sv
// ----------------------------------------------------------------------------
// Blocking message queue RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sim/tb_blocking_message_queue.sv
// ----------------------------------------------------------------------------
// Blocking message queue testbench
// Command words go in through a throttled stream driver. A predictor holds its
// own copy of the ring, the wait lists and the registers, and the expected
// result words are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_blocking_message_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import bmq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] task_id;
    logic [MSG_W-1:0]  msg;
    logic              no_wait;
    logic              sched;
  } cmd_word_t;

  typedef struct packed {
    logic [TASK_W-1:0] target;
    logic              wake;
    logic [ST_W-1:0]   status;
    logic [MSG_W-1:0]  msg;
    logic              last;
  } result_word_t;

  // directed row: a command word, plus a typed-in reply where it is obvious
  typedef struct packed {
    cmd_word_t       word;
    logic            typed;
    logic [ST_W-1:0] reply_st;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = '0;
  logic [CAP_W-1:0] cfg_data = '0;

  blocking_message_queue uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [MSG_W-1:0]  ring_mem [RING_DEPTH];
  int unsigned       rd_idx, wr_idx, fill_cnt;
  bit                queue_alive;
  logic [TASK_W-1:0] blocked_senders[$];
  logic [MSG_W-1:0]  blocked_msgs[$];
  logic [TASK_W-1:0] blocked_receivers[$];
  logic [CAP_W-1:0]  capacity_reg;
  logic [NB_W-1:0]   bytes_reg;

  result_word_t pending_results[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int unsigned live_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > RING_DEPTH) return RING_DEPTH;
    return capacity_reg;
  endfunction

  function automatic logic [MSG_W-1:0] keep_bytes(logic [MSG_W-1:0] m);
    int unsigned b;
    b = (bytes_reg == 0) ? 1 : bytes_reg;
    if (b >= 8) return m;
    return m & ((64'd1 << (8 * b)) - 64'd1);
  endfunction

  function automatic int unsigned step_ptr(int unsigned p);
    return (p + 1 >= live_capacity()) ? 0 : p + 1;
  endfunction

  function automatic void expect_word(logic [TASK_W-1:0] t, logic w, logic [ST_W-1:0] st,
                                      logic [MSG_W-1:0] m, logic l);
    pending_results.push_back('{target: t, wake: w, status: st, msg: m, last: l});
  endfunction

  function automatic void ring_put(logic [MSG_W-1:0] m);
    ring_mem[wr_idx] = keep_bytes(m);
    wr_idx = step_ptr(wr_idx);
    fill_cnt++;
  endfunction

  // work out the result words of one accepted command and advance the state
  function automatic void predict_queue_op(cmd_word_t w);
    logic [MSG_W-1:0] m;
    if (w.cmd > CMD_DELETE) begin
      expect_word(w.task_id, 1'b0, ST_INVALID, '0, 1'b1);
      return;
    end
    if (w.cmd == CMD_CANCEL) begin
      if (queue_alive) begin
        foreach (blocked_senders[i]) if (blocked_senders[i] == w.task_id) begin
          blocked_senders.delete(i);
          blocked_msgs.delete(i);
          expect_word(w.task_id, 1'b0, ST_OK, '0, 1'b1);
          return;
        end
        foreach (blocked_receivers[i]) if (blocked_receivers[i] == w.task_id) begin
          blocked_receivers.delete(i);
          expect_word(w.task_id, 1'b0, ST_OK, '0, 1'b1);
          return;
        end
      end
      expect_word(w.task_id, 1'b0, ST_NOTFOUND, '0, 1'b1);
      return;
    end
    if (!queue_alive) begin
      expect_word(w.task_id, 1'b0, ST_INVALID, '0, 1'b1);
      return;
    end
    if (w.cmd == CMD_DELETE) begin
      foreach (blocked_senders[i]) expect_word(blocked_senders[i], 1'b1, ST_ERROR, '0, 1'b0);
      foreach (blocked_receivers[i])
        expect_word(blocked_receivers[i], 1'b1, ST_ERROR, '0, 1'b0);
      blocked_senders.delete();
      blocked_msgs.delete();
      blocked_receivers.delete();
      queue_alive = 0;
      expect_word(w.task_id, 1'b0, ST_OK, '0, 1'b1);
      return;
    end
    if (w.cmd != CMD_SEND_ISR && !w.sched) begin
      expect_word(w.task_id, 1'b0, ST_ERROR, '0, 1'b1);
      return;
    end
    if (w.cmd == CMD_SEND || w.cmd == CMD_SEND_ISR) begin
      if (blocked_receivers.size() > 0) begin
        // hand the data straight to the oldest waiting receiver
        expect_word(blocked_receivers.pop_front(), 1'b1, ST_OK, keep_bytes(w.msg), 1'b0);
        expect_word(w.task_id, 1'b0, ST_OK, '0, 1'b1);
      end else if (fill_cnt < live_capacity()) begin
        ring_put(w.msg);
        expect_word(w.task_id, 1'b0, ST_OK, '0, 1'b1);
      end else if (w.cmd == CMD_SEND_ISR) begin
        expect_word(w.task_id, 1'b0, ST_BUSY, '0, 1'b1);
      end else if (w.no_wait) begin
        expect_word(w.task_id, 1'b0, ST_TIMEOUT, '0, 1'b1);
      end else if (blocked_senders.size() >= MAX_WAITERS) begin
        expect_word(w.task_id, 1'b0, ST_BUSY, '0, 1'b1);
      end else begin
        blocked_senders.push_back(w.task_id);
        blocked_msgs.push_back(keep_bytes(w.msg));
        expect_word(w.task_id, 1'b0, ST_BLOCKED, '0, 1'b1);
      end
      return;
    end
    // receive
    if (fill_cnt > 0) begin
      m = keep_bytes(ring_mem[rd_idx]);
      rd_idx = step_ptr(rd_idx);
      fill_cnt--;
      if (blocked_senders.size() > 0) begin
        // refill from the oldest blocked sender and wake it
        ring_put(blocked_msgs.pop_front());
        expect_word(blocked_senders.pop_front(), 1'b1, ST_OK, '0, 1'b0);
      end
      expect_word(w.task_id, 1'b0, ST_OK, m, 1'b1);
    end else if (w.no_wait) begin
      expect_word(w.task_id, 1'b0, ST_TIMEOUT, '0, 1'b1);
    end else if (blocked_receivers.size() >= MAX_WAITERS) begin
      expect_word(w.task_id, 1'b0, ST_BUSY, '0, 1'b1);
    end else begin
      blocked_receivers.push_back(w.task_id);
      expect_word(w.task_id, 1'b0, ST_BLOCKED, '0, 1'b1);
    end
  endfunction

  // offer one command word, with random idle cycles ahead of it
  task automatic offer_word(cmd_word_t w);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, w.msg, w.task_id};
    s_tuser  <= {w.sched, w.no_wait, w.cmd};
    do @(posedge clk); while (!s_tready);
    predict_queue_op(w);
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  // write one register; only called while the block is idle
  task automatic write_reg(logic [0:0] idx, logic [CAP_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) capacity_reg = val;
    else bytes_reg = val[NB_W-1:0];
    @(posedge clk);
  endtask

  // empty the ring and the blocked senders so a capacity change never strands data
  task automatic drain_ring();
    while (fill_cnt > 0 || blocked_senders.size() > 0)
      offer_word('{cmd: CMD_RECV, task_id: 4'($urandom_range(15)), msg: '0,
                   no_wait: 1'b1, sched: 1'b1});
    go_quiet();
  endtask

  function automatic cmd_word_t random_word(int send_pct);
    cmd_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.task_id = 4'($urandom_range(15));
    w.msg     = {$urandom(), $urandom()};
    w.no_wait = ($urandom_range(99) < 25);
    w.sched   = ($urandom_range(99) < 94);
    if (pick < 4) w.cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    else if (pick < 12) w.cmd = CMD_CANCEL;
    else if (pick < 12 + send_pct * 88 / 100)
      w.cmd = ($urandom_range(99) < 20) ? CMD_SEND_ISR : CMD_SEND;
    else w.cmd = CMD_RECV;
    return w;
  endfunction

  localparam directed_row_t DIRECTED[20] = '{
    '{'{CMD_RECV,     4'd0,  64'h0, 1'b0, 1'b0}, 1'b1, ST_ERROR},
    '{'{CMD_SEND,     4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}, 1'b1, ST_ERROR},
    '{'{CMD_UNKNOWN_HI, 4'd4, 64'h0, 1'b0, 1'b1}, 1'b1, ST_INVALID},
    '{'{CMD_UNKNOWN_LO, 4'd5, 64'h0, 1'b1, 1'b0}, 1'b1, ST_INVALID},
    '{'{CMD_RECV,     4'd1,  64'h0, 1'b1, 1'b1}, 1'b1, ST_TIMEOUT},
    '{'{CMD_CANCEL,   4'd9,  64'h0, 1'b0, 1'b1}, 1'b1, ST_NOTFOUND},
    '{'{CMD_RECV,     4'd3,  64'h0, 1'b0, 1'b1}, 1'b1, ST_BLOCKED},
    '{'{CMD_RECV,     4'd3,  64'h0, 1'b0, 1'b1}, 1'b1, ST_BLOCKED},
    '{'{CMD_SEND,     4'd1,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1}, 1'b0, ST_OK},
    '{'{CMD_SEND_ISR, 4'd2,  64'h0, 1'b0, 1'b0}, 1'b0, ST_OK},
    '{'{CMD_CANCEL,   4'd3,  64'h0, 1'b0, 1'b1}, 1'b1, ST_NOTFOUND},
    '{'{CMD_SEND_ISR, 4'd15, 64'hA5C3_0F1E_8765_4321, 1'b1, 1'b0}, 1'b0, ST_OK},
    '{'{CMD_SEND_ISR, 4'd6,  64'h1, 1'b0, 1'b1}, 1'b1, ST_BUSY},
    '{'{CMD_SEND,     4'd7,  64'h2, 1'b1, 1'b1}, 1'b1, ST_TIMEOUT},
    '{'{CMD_SEND,     4'd5,  64'hFEDC_BA98_7654_3210, 1'b0, 1'b1}, 1'b1, ST_BLOCKED},
    '{'{CMD_RECV,     4'd8,  64'h0, 1'b0, 1'b1}, 1'b0, ST_OK},
    '{'{CMD_CANCEL,   4'd5,  64'h0, 1'b0, 1'b1}, 1'b1, ST_NOTFOUND},
    '{'{CMD_SEND,     4'd10, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b1}, 1'b1, ST_BLOCKED},
    '{'{CMD_RECV,     4'd0,  64'h0, 1'b1, 1'b1}, 1'b0, ST_OK},
    '{'{CMD_RECV,     4'd11, 64'h0, 1'b0, 1'b1}, 1'b0, ST_OK}
  };

  // result side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
    end
  end

  // compare each result word against the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: task %0d status %0d", m_tdata[3:0], m_tuser[3:1]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[3:0] !== want.target) begin
          $error("target_task: expected %0d, got %0d", want.target, m_tdata[3:0]);
          mismatches++;
        end
        if (m_tuser[0] !== want.wake) begin
          $error("is_wake: expected %0d, got %0d", want.wake, m_tuser[0]);
          mismatches++;
        end
        if (m_tuser[3:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[3:1]);
          mismatches++;
        end
        if (m_tdata[67:4] !== want.msg) begin
          $error("msg_out: expected %h, got %h", want.msg, m_tdata[67:4]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog: count cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned caps  [6] = '{2, 256, 0, 511, 3, 16};
    int unsigned bytes [6] = '{1, 8, 15, 0, 2, 4};
    int send_pcts      [6] = '{70, 55, 60, 40, 25, 80};
    int sidle          [6] = '{0, 56, 0, 29, 0, 29};
    int ridle          [6] = '{0, 0, 56, 29, 0, 29};
    rd_idx = 0;
    wr_idx = 0;
    fill_cnt = 0;
    queue_alive = 1;
    capacity_reg = CAP_RESET;
    bytes_reg = BYTES_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk: capacity 1 makes full-queue cases easy, bytes stay at reset
    write_reg(REG_CAPACITY, 9'd1);
    foreach (DIRECTED[i]) begin
      offer_word(DIRECTED[i].word);
      if (DIRECTED[i].typed) begin
        // typed rows give a lone reply; it is the newest expectation
        void'(pending_results.pop_back());
        expect_word(DIRECTED[i].word.task_id, 1'b0, DIRECTED[i].reply_st, '0, 1'b1);
      end
    end
    drain_ring();

    // random phases, each under its own register setting and throttling
    foreach (caps[p]) begin
      write_reg(REG_CAPACITY, CAP_W'(caps[p]));
      write_reg(REG_MSG_BYTES, CAP_W'(bytes[p]));
      sender_idle_pct = sidle[p];
      receiver_idle_pct = ridle[p];
      // one phase parks the result side so the block backs up into its input
      if (p == 2) hold_left = LONG_HOLD;
      repeat (67) offer_word(random_word(send_pcts[p]));
      // drain the ring, then hold the sender until every pending result has arrived
      drain_ring();
    end

    // delete with blocked receivers, then hit the dead queue
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (6) offer_word('{cmd: CMD_RECV, task_id: 4'($urandom_range(15)), msg: '0,
                            no_wait: 1'b0, sched: 1'b1});
    offer_word('{cmd: CMD_DELETE, task_id: 4'd12, msg: '0, no_wait: 1'b0, sched: 1'b0});
    offer_word('{cmd: CMD_SEND, task_id: 4'd1, msg: 64'h7, no_wait: 1'b0, sched: 1'b1});
    offer_word('{cmd: CMD_SEND_ISR, task_id: 4'd2, msg: 64'h8, no_wait: 1'b1, sched: 1'b0});
    offer_word('{cmd: CMD_RECV, task_id: 4'd3, msg: '0, no_wait: 1'b0, sched: 1'b1});
    offer_word('{cmd: CMD_DELETE, task_id: 4'd4, msg: '0, no_wait: 1'b0, sched: 1'b1});
    offer_word('{cmd: CMD_CANCEL, task_id: 4'd5, msg: '0, no_wait: 1'b0, sched: 1'b1});
    s_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
